/* sv/llf_pkg.sv */
// Lead-lag filter package: fixed widths, register indexes and the structs
// shared by the sequencer, the divider and the multiplier. No dependencies.
package llf_pkg;

  localparam int DATA_WIDTH    = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DT_W          = 16;
  // Numerators and denominator: 2*c << DT_W plus dt*c, exact
  localparam int NUM_W         = DATA_WIDTH + DT_W + 2;
  localparam int MAG_W         = NUM_W - 1;
  // Quotient bits kept by the divider: the result width plus a rounding bit
  localparam int QUOT_W        = DATA_WIDTH + 1;
  localparam int OP_W          = DATA_WIDTH + 1;
  localparam int PROD_W        = 2 * OP_W;
  localparam int REG_IDX_W     = 2;

  localparam logic [REG_IDX_W-1:0] REG_LEAD_S = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_LEAD_0 = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LAG_S  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_LAG_0  = 2'd3;

  localparam logic signed [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [DT_W-1:0]              step_time;
    logic signed [DATA_WIDTH-1:0] sample_in;
  } sample_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] filtered_out;
    logic                         zero_denominator;
    logic                         saturated;
  } result_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [NUM_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                         done;
    logic                         sat;
    logic signed [DATA_WIDTH-1:0] quot;
  } div_res_t;

endpackage

/* sv/llf_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on llf_pkg for operand and product widths.
module llf_mul (
  input  logic                             clk,
  input  logic signed [llf_pkg::OP_W-1:0]   a,
  input  logic signed [llf_pkg::OP_W-1:0]   b,
  output logic signed [llf_pkg::PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

/* sv/llf_div.sv */
// Restoring divider for the filter coefficients: round(num * 2^FRAC_BITS / den),
// ties away from zero, saturated. One quotient bit per cycle. Depends on llf_pkg.
module llf_div #(
  parameter int FRAC_BITS = llf_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  llf_pkg::div_req_t req,
  output llf_pkg::div_res_t res
);

  localparam int DW    = llf_pkg::DATA_WIDTH;
  localparam int MAG_W = llf_pkg::MAG_W;
  localparam int NUM_W = llf_pkg::NUM_W;
  localparam int QW    = llf_pkg::QUOT_W;
  localparam int SHIFT = DW - FRAC_BITS;
  localparam int CNT_W = $clog2(QW + 1);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_PRE  = 2'd1;
  localparam logic [1:0] D_ITER = 2'd2;
  localparam logic [1:0] D_FIN  = 2'd3;

  localparam logic [QW-1:0] Q_LIM = QW'(1) << (DW - 1);

  logic [1:0]       dstate;
  logic [MAG_W-1:0] n_mag;
  logic [MAG_W-1:0] d_mag;
  logic             neg;
  logic             ovf;
  logic [MAG_W-1:0] rem;
  logic [QW-1:0]    low;
  logic [QW-1:0]    quo;
  logic [CNT_W-1:0] cnt;

  logic signed [NUM_W-1:0] num_abs;
  logic signed [NUM_W-1:0] den_abs;
  logic [MAG_W-1:0]        n_hi;
  logic [MAG_W:0]          trial;
  logic [MAG_W:0]          diff;
  logic                    ge;
  logic [QW:0]             q_inc;
  logic [QW-1:0]           q_rnd;
  logic [QW-1:0]           q_neg;

  always_comb begin
    num_abs = req.num[NUM_W-1] ? -req.num : req.num;
    den_abs = req.den[NUM_W-1] ? -req.den : req.den;
    n_hi    = n_mag >> SHIFT;
    trial   = {rem, low[QW-1]};
    diff    = trial - {1'b0, d_mag};
    ge      = trial >= {1'b0, d_mag};
    q_inc   = {1'b0, quo} + (QW+1)'(1);
    q_rnd   = q_inc[QW:1];
    q_neg   = -q_rnd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate   <= D_IDLE;
      res.done <= 1'b0;
    end else begin
      res.done <= dstate == D_FIN;
      case (dstate)
        D_IDLE: begin
          if (req.start) begin
            n_mag  <= num_abs[MAG_W-1:0];
            d_mag  <= den_abs[MAG_W-1:0];
            neg    <= req.num[NUM_W-1] ^ req.den[NUM_W-1];
            dstate <= D_PRE;
          end
        end
        D_PRE: begin
          // Quotient must fit in QW bits, else the result saturates
          rem    <= n_hi;
          ovf    <= n_hi >= d_mag;
          low    <= {n_mag[SHIFT-1:0], {(FRAC_BITS+1){1'b0}}};
          quo    <= '0;
          cnt    <= CNT_W'(QW);
          dstate <= D_ITER;
        end
        D_ITER: begin
          rem <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
          low <= low << 1;
          quo <= {quo[QW-2:0], ge};
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            dstate <= D_FIN;
          end
        end
        D_FIN: begin
          if (ovf) begin
            res.sat  <= 1'b1;
            res.quot <= neg ? llf_pkg::DATA_MIN : llf_pkg::DATA_MAX;
          end else if (neg) begin
            res.sat  <= q_rnd > Q_LIM;
            res.quot <= (q_rnd > Q_LIM) ? llf_pkg::DATA_MIN : q_neg[DW-1:0];
          end else begin
            res.sat  <= q_rnd >= Q_LIM;
            res.quot <= (q_rnd >= Q_LIM) ? llf_pkg::DATA_MAX : q_rnd[DW-1:0];
          end
          dstate <= D_IDLE;
        end
        default: dstate <= D_IDLE;
      endcase
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> dstate == D_IDLE)
    else $error("divider started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    res.done |=> !res.done)
    else $error("divider done held longer than one cycle");

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    res.done && res.sat |-> res.quot == llf_pkg::DATA_MAX || res.quot == llf_pkg::DATA_MIN)
    else $error("saturated quotient not at a limit");

endmodule

/* sv/lead_lag_filter_top.sv */
// First-order lead-lag filter (c1*s + c2)/(c3*s + c4), Tustin form, in signed
// Q16.16 with FRAC_BITS fraction bits; uses llf_pkg, llf_div and llf_mul. One
// item is worked on at a time: an item with step_time zero returns the held
// output, one with a zero denominator returns it flagged once the denominator
// is checked, and a normal item spends nearly all of its time in the one
// restoring divider, which yields a quotient bit per cycle and is used once
// for each of the three coefficients; the shared multiplier then sums the
// three products. The next transfer can follow in the cycle after the result
// is loaded; the result may first wait on result_stall.
// sample_stall stays high from the transfer until the result is loaded into
// the output register, which holds it until its own transfer.
module lead_lag_filter_top #(
  parameter int FRAC_BITS = llf_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [llf_pkg::REG_IDX_W-1:0]        wr_index,
  input  logic [llf_pkg::DATA_WIDTH-1:0]       wr_data,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  llf_pkg::sample_t                     sample,
  output logic                                result_valid,
  input  logic                                result_stall,
  output llf_pkg::result_t                     result
);

  localparam int DW     = llf_pkg::DATA_WIDTH;
  localparam int DT_W   = llf_pkg::DT_W;
  localparam int NUM_W  = llf_pkg::NUM_W;
  localparam int OP_W   = llf_pkg::OP_W;
  localparam int PROD_W = llf_pkg::PROD_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MUL1    = 4'd1;
  localparam logic [3:0] S_MUL2    = 4'd2;
  localparam logic [3:0] S_SUMDEN  = 4'd3;
  localparam logic [3:0] S_CHKDEN  = 4'd4;
  localparam logic [3:0] S_DIVGO   = 4'd5;
  localparam logic [3:0] S_DIVWAIT = 4'd6;
  localparam logic [3:0] S_MAC     = 4'd7;
  localparam logic [3:0] S_ROUND   = 4'd8;
  localparam logic [3:0] S_OUT     = 4'd9;

  localparam logic [1:0] COEF_A = 2'd0;
  localparam logic [1:0] COEF_B = 2'd1;
  localparam logic [1:0] COEF_C = 2'd2;

  localparam logic signed [PROD_W-1:0] Y_HI =
    {{(PROD_W-DW){1'b0}}, llf_pkg::DATA_MAX};
  localparam logic signed [PROD_W-1:0] Y_LO =
    {{(PROD_W-DW){1'b1}}, llf_pkg::DATA_MIN};
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

  logic signed [DW-1:0] lead_gain_s;
  logic signed [DW-1:0] lead_gain_0;
  logic signed [DW-1:0] lag_gain_s;
  logic signed [DW-1:0] lag_gain_0;

  logic signed [DW-1:0] prev_input;
  logic signed [DW-1:0] prev_output;
  logic signed [DW-1:0] held_output;

  logic [3:0]              state;
  logic [DT_W-1:0]         dt;
  logic signed [DW-1:0]    u;
  logic signed [NUM_W-1:0] dtc2;
  logic signed [NUM_W-1:0] dtc4;
  logic signed [NUM_W-1:0] den;
  logic signed [NUM_W-1:0] num;
  logic [1:0]              coef_idx;
  logic signed [DW-1:0]    coef [3];
  logic [1:0]              mstep;
  logic signed [PROD_W-1:0] acc;
  logic                    zden;
  logic                    sat;

  logic signed [OP_W-1:0]   op_a;
  logic signed [OP_W-1:0]   op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [NUM_W-1:0]  two_c1;
  logic signed [NUM_W-1:0]  two_c3;
  logic [1:0]               num_sel;
  logic signed [NUM_W-1:0]  num_new;
  logic signed [PROD_W-1:0] rnd_sum;
  logic signed [PROD_W-1:0] y_wide;
  llf_pkg::div_req_t        div_req;
  llf_pkg::div_res_t        div_res;

  assign sample_stall = state != S_IDLE;

  // 2*c scaled into the dt*c product units
  assign two_c1 = {lead_gain_s[DW-1], lead_gain_s, {(DT_W+1){1'b0}}};
  assign two_c3 = {lag_gain_s[DW-1], lag_gain_s, {(DT_W+1){1'b0}}};

  always_comb begin
    num_sel = (state == S_CHKDEN) ? COEF_A : coef_idx + 2'd1;
    case (num_sel)
      COEF_A:  num_new = two_c1 + dtc2;
      COEF_B:  num_new = dtc2 - two_c1;
      COEF_C:  num_new = two_c3 - dtc4;
      default: num_new = '0;
    endcase
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      S_MUL1: begin
        op_a = {{(OP_W-DT_W){1'b0}}, dt};
        op_b = {lead_gain_0[DW-1], lead_gain_0};
      end
      S_MUL2: begin
        op_a = {{(OP_W-DT_W){1'b0}}, dt};
        op_b = {lag_gain_0[DW-1], lag_gain_0};
      end
      S_MAC: begin
        case (mstep)
          2'd0: begin
            op_a = {coef[0][DW-1], coef[0]};
            op_b = {u[DW-1], u};
          end
          2'd1: begin
            op_a = {coef[1][DW-1], coef[1]};
            op_b = {prev_input[DW-1], prev_input};
          end
          2'd2: begin
            op_a = {coef[2][DW-1], coef[2]};
            op_b = {prev_output[DW-1], prev_output};
          end
          default: begin
            op_a = '0;
            op_b = '0;
          end
        endcase
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Round half up on the exact sum, then clip
  assign rnd_sum = acc + HALF;
  assign y_wide  = rnd_sum >>> FRAC_BITS;

  assign div_req = {state == S_DIVGO, num, den};

  llf_mul u_mul (
    .clk  (clk),
    .a    (op_a),
    .b    (op_b),
    .prod (prod)
  );

  llf_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_gain_s <= '0;
      lead_gain_0 <= '0;
      lag_gain_s  <= '0;
      lag_gain_0  <= '0;
    end else if (wr_en) begin
      case (wr_index)
        llf_pkg::REG_LEAD_S: lead_gain_s <= wr_data;
        llf_pkg::REG_LEAD_0: lead_gain_0 <= wr_data;
        llf_pkg::REG_LAG_S:  lag_gain_s  <= wr_data;
        llf_pkg::REG_LAG_0:  lag_gain_0  <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      prev_input   <= '0;
      prev_output  <= '0;
      held_output  <= '0;
      coef_idx     <= COEF_A;
      mstep        <= 2'd0;
    end else begin
      // a fresh load in S_OUT takes over from the clear
      if (result_valid && !result_stall && state != S_OUT) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            dt   <= sample.step_time;
            u    <= sample.sample_in;
            zden <= 1'b0;
            sat  <= 1'b0;
            state <= (sample.step_time == '0) ? S_OUT : S_MUL1;
          end
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: begin
          dtc2  <= prod[NUM_W-1:0];
          state <= S_SUMDEN;
        end
        S_SUMDEN: begin
          dtc4  <= prod[NUM_W-1:0];
          den   <= two_c3 + prod[NUM_W-1:0];
          state <= S_CHKDEN;
        end
        S_CHKDEN: begin
          if (den == '0) begin
            zden  <= 1'b1;
            state <= S_OUT;
          end else begin
            num      <= num_new;
            coef_idx <= COEF_A;
            state    <= S_DIVGO;
          end
        end
        S_DIVGO: state <= S_DIVWAIT;
        S_DIVWAIT: begin
          if (div_res.done) begin
            coef[coef_idx] <= div_res.quot;
            sat            <= sat | div_res.sat;
            if (coef_idx == COEF_C) begin
              mstep <= 2'd0;
              state <= S_MAC;
            end else begin
              coef_idx <= coef_idx + 2'd1;
              num      <= num_new;
              state    <= S_DIVGO;
            end
          end
        end
        S_MAC: begin
          // the registered product belongs to the previous step's operands
          acc   <= (mstep == 2'd0) ? '0 : acc + prod;
          mstep <= mstep + 2'd1;
          if (mstep == 2'd3) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          prev_input <= u;
          if (y_wide > Y_HI) begin
            prev_output <= llf_pkg::DATA_MAX;
            held_output <= llf_pkg::DATA_MAX;
            sat         <= 1'b1;
          end else if (y_wide < Y_LO) begin
            prev_output <= llf_pkg::DATA_MIN;
            held_output <= llf_pkg::DATA_MIN;
            sat         <= 1'b1;
          end else begin
            prev_output <= y_wide[DW-1:0];
            held_output <= y_wide[DW-1:0];
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!result_valid || !result_stall) begin
            result.filtered_out     <= held_output;
            result.zero_denominator <= zden;
            result.saturated        <= sat;
            result_valid            <= 1'b1;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_zden_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.zero_denominator |-> !result.saturated)
    else $error("zero denominator result flagged as saturated");

  a_coef_idx: assert property (@(posedge clk) disable iff (rst)
    state == S_DIVWAIT |-> coef_idx <= COEF_C)
    else $error("coefficient index out of range");

  a_hold_fast: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall && sample.step_time == '0 |=> state == S_OUT)
    else $error("hold item did not go straight to output");

endmodule
